>>> rtl/core/hsh_pkg.sv
// Shared types and constants for the hyperplane sign hash block.
package hsh_pkg;

  localparam int DIMENSIONS_DEFAULT = 128;
  localparam int PLANES_DEFAULT     = 16;

  localparam int VALUE_W = 16;   // Q4.12
  localparam int PROD_W  = 32;   // Q8.24
  localparam int SUM_W   = 40;   // Q16.24
  localparam int SIG_W   = 16;
  localparam int VNUM_W  = 16;
  localparam int LEN_W   = 8;
  localparam int PLANE_W = 4;
  localparam int DIM_W   = 7;

  localparam logic [LEN_W-1:0] LEN_RESET = 8'd128;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DATA = 1'b1
  } opcode_t;

  // control that travels alongside an element through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  // result word as it appears on m_tdata
  typedef struct packed {
    logic [VNUM_W-1:0] vector_number;
    logic [SIG_W-1:0]  signature;
  } result_t;

endpackage

>>> rtl/core/hsh_coef_store.sv
// Coefficient memory: one row per vector position, one lane per plane.
module hsh_coef_store #(
  parameter int DIMENSIONS = hsh_pkg::DIMENSIONS_DEFAULT,
  parameter int PLANES     = hsh_pkg::PLANES_DEFAULT,
  parameter int AW         = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1
) (
  input  logic                                  clk,
  input  logic [AW-1:0]                         waddr,
  input  logic [PLANES-1:0]                     lane_we,
  input  logic [hsh_pkg::VALUE_W-1:0]           wdata,
  input  logic                                  re,
  input  logic [AW-1:0]                         raddr,
  output logic [PLANES-1:0][hsh_pkg::VALUE_W-1:0] rdata
);

  logic [PLANES-1:0][hsh_pkg::VALUE_W-1:0] mem [DIMENSIONS];

  always_ff @(posedge clk) begin
    for (int j = 0; j < PLANES; j++) begin
      if (lane_we[j]) begin
        mem[waddr][j] <= wdata;
      end
    end
  end

  // read and write never hit in the same cycle: only one transaction per edge
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/hsh_mac_lanes.sv
// Per-plane multiply and accumulate lanes, sign test and vector count.
module hsh_mac_lanes #(
  parameter int PLANES = hsh_pkg::PLANES_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  hsh_pkg::stage_ctl_t                     in_ctl,
  input  logic [hsh_pkg::VALUE_W-1:0]             element,
  input  logic [PLANES-1:0][hsh_pkg::VALUE_W-1:0] coef,
  output logic                                    last_pending,
  output logic                                    push,
  output hsh_pkg::result_t                        push_data
);

  localparam int SIGX_W = (PLANES > hsh_pkg::SIG_W) ? PLANES : hsh_pkg::SIG_W;

  hsh_pkg::stage_ctl_t               p2_ctl;
  logic signed [hsh_pkg::PROD_W-1:0] prod    [PLANES];
  logic signed [hsh_pkg::SUM_W-1:0]  sums    [PLANES];
  logic signed [hsh_pkg::SUM_W-1:0]  sum_upd [PLANES];
  logic [hsh_pkg::VNUM_W-1:0]        vector_counter;
  logic [SIGX_W-1:0]                 sig_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_ctl <= '0;
    end else begin
      p2_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      for (int j = 0; j < PLANES; j++) begin
        prod[j] <= $signed(element) * $signed(coef[j]);
      end
    end
  end

  always_comb begin
    sig_wide = '0;
    for (int j = 0; j < PLANES; j++) begin
      sum_upd[j] = sums[j] + hsh_pkg::SUM_W'(prod[j]);
      sig_wide[PLANES-1-j] = !sum_upd[j][hsh_pkg::SUM_W-1] && (sum_upd[j] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_counter <= '0;
      for (int j = 0; j < PLANES; j++) begin
        sums[j] <= '0;
      end
    end else if (p2_ctl.valid) begin
      for (int j = 0; j < PLANES; j++) begin
        sums[j] <= p2_ctl.last ? '0 : sum_upd[j];
      end
      if (p2_ctl.last) begin
        vector_counter <= vector_counter + 1'b1;
      end
    end
  end

  assign push                    = p2_ctl.valid && p2_ctl.last;
  assign push_data.signature     = sig_wide[hsh_pkg::SIG_W-1:0];
  assign push_data.vector_number = vector_counter;
  assign last_pending            = p2_ctl.valid && p2_ctl.last;

endmodule

>>> rtl/core/hsh_out_fifo.sv
// Small result queue between the accumulators and the output stream.
module hsh_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  hsh_pkg::result_t                push_data,
  input  logic                            pop_ready,
  output logic                            out_valid,
  output hsh_pkg::result_t                out_data,
  output logic [hsh_pkg::OUT_CNT_W-1:0]   count
);

  hsh_pkg::result_t                entries [hsh_pkg::OUT_DEPTH];
  logic [hsh_pkg::OUT_PTR_W-1:0]   wr_ptr;
  logic [hsh_pkg::OUT_PTR_W-1:0]   rd_ptr;
  logic                            pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/hyperplane_sign_hash.sv
// Random-hyperplane sign hash: one transaction per cycle while s_tready is high, loads
// and elements alike. A load writes one coefficient into its plane's lane of the row for
// its vector position; an element reads the whole row, multiplies it against all planes
// in parallel and adds the products into 40-bit sums; the pipeline is three deep (memory
// read, multiply, accumulate). The signature of the vector is taken from the sums at the
// accumulate stage of the element that completes it and waits in a four-entry result
// queue; s_tready only drops when that queue together with the results still in the
// pipeline would overflow, which with a consumer that keeps up never happens.
module hyperplane_sign_hash #(
  parameter int DIMENSIONS = hsh_pkg::DIMENSIONS_DEFAULT,
  parameter int PLANES     = hsh_pkg::PLANES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // plane_index, dim_index, value, zero pad
  input  logic [0:0]                s_tuser,   // opcode
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [31:0]               m_tdata,   // signature, vector_number
  input  logic                      cfg_we,
  input  logic [hsh_pkg::LEN_W-1:0] cfg_wdata  // vector_length
);

  localparam int AW     = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int CNT_W  = ($clog2(DIMENSIONS + 1) > hsh_pkg::LEN_W) ?
                          $clog2(DIMENSIONS + 1) : hsh_pkg::LEN_W;
  localparam int PCMP_W = ($clog2(PLANES + 1) > hsh_pkg::PLANE_W) ?
                          $clog2(PLANES + 1) : hsh_pkg::PLANE_W + 1;

  logic [hsh_pkg::PLANE_W-1:0] plane_index;
  logic [hsh_pkg::DIM_W-1:0]   dim_index;
  logic [hsh_pkg::VALUE_W-1:0] value;
  hsh_pkg::opcode_t            opcode;

  logic [hsh_pkg::LEN_W-1:0]   vector_length;
  logic [AW-1:0]               position;
  logic [AW-1:0]               position_next;
  logic [CNT_W-1:0]            len_ext;
  logic [CNT_W-1:0]            eff_len;
  logic [CNT_W-1:0]            pos_inc;
  logic [CNT_W-1:0]            dim_ext;
  logic                        is_last;

  logic                        accept;
  logic                        accept_data;
  logic                        load_ok;
  logic [PLANES-1:0]           lane_we;

  hsh_pkg::stage_ctl_t         p1_ctl;
  logic [hsh_pkg::VALUE_W-1:0] p1_value;
  logic [PLANES-1:0][hsh_pkg::VALUE_W-1:0] coef;

  logic                        p2_last;
  logic                        push;
  hsh_pkg::result_t            push_data;
  hsh_pkg::result_t            out_data;
  logic [hsh_pkg::OUT_CNT_W-1:0] fifo_count;
  logic [hsh_pkg::OUT_CNT_W:0]   outstanding;

  assign plane_index = s_tdata[3:0];
  assign dim_index   = s_tdata[10:4];
  assign value       = s_tdata[26:11];
  assign opcode      = hsh_pkg::opcode_t'(s_tuser[0]);

  assign accept      = s_tvalid && s_tready;
  assign accept_data = accept && (opcode == hsh_pkg::OP_DATA);

  // length clamped into 1..DIMENSIONS
  always_comb begin
    len_ext = CNT_W'(vector_length);
    if (len_ext == '0) begin
      eff_len = CNT_W'(1);
    end else if (len_ext > CNT_W'(DIMENSIONS)) begin
      eff_len = CNT_W'(DIMENSIONS);
    end else begin
      eff_len = len_ext;
    end
    pos_inc       = CNT_W'(position) + CNT_W'(1);
    is_last       = (pos_inc >= eff_len);
    position_next = is_last ? '0 : pos_inc[AW-1:0];
  end

  // out-of-range loads are dropped
  always_comb begin
    dim_ext = CNT_W'(dim_index);
    load_ok = accept && (opcode == hsh_pkg::OP_LOAD) &&
              (dim_ext < CNT_W'(DIMENSIONS)) &&
              (PCMP_W'(plane_index) < PCMP_W'(PLANES));
    for (int j = 0; j < PLANES; j++) begin
      lane_we[j] = load_ok && (PCMP_W'(plane_index) == PCMP_W'(j));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= hsh_pkg::LEN_RESET;
    end else if (cfg_we) begin
      vector_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      p1_ctl   <= '0;
    end else begin
      p1_ctl.valid <= accept_data;
      p1_ctl.last  <= accept_data && is_last;
      if (accept_data) begin
        position <= position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_data) begin
      p1_value <= value;
    end
  end

  hsh_coef_store #(
    .DIMENSIONS (DIMENSIONS),
    .PLANES     (PLANES),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .waddr   (dim_ext[AW-1:0]),
    .lane_we (lane_we),
    .wdata   (value),
    .re      (accept_data),
    .raddr   (position),
    .rdata   (coef)
  );

  hsh_mac_lanes #(
    .PLANES (PLANES)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .in_ctl       (p1_ctl),
    .element      (p1_value),
    .coef         (coef),
    .last_pending (p2_last),
    .push         (push),
    .push_data    (push_data)
  );

  hsh_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  assign m_tdata = out_data;

  // queued results plus those still in flight must leave room for one more
  assign outstanding = (hsh_pkg::OUT_CNT_W + 1)'(fifo_count) +
                       (hsh_pkg::OUT_CNT_W + 1)'(p1_ctl.last) +
                       (hsh_pkg::OUT_CNT_W + 1)'(p2_last);
  assign s_tready    = (outstanding < (hsh_pkg::OUT_CNT_W + 1)'(hsh_pkg::OUT_DEPTH));

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    outstanding <= (hsh_pkg::OUT_CNT_W + 1)'(hsh_pkg::OUT_DEPTH))
    else $error("result queue credit exceeded");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    accept_data && is_last |=> position == '0)
    else $error("position not cleared after last element");

  a_push_follows: assert property (@(posedge clk) disable iff (rst)
    accept_data && is_last |=> ##1 push)
    else $error("completed vector did not produce a result");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the hyperplane sign hash block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIMS          = hsh_pkg::DIMENSIONS_DEFAULT;
  localparam int NPLANES       = hsh_pkg::PLANES_DEFAULT;
  localparam int FILL_ROWS     = 16;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTS    = 30;

  typedef struct packed {
    hsh_pkg::opcode_t                op;
    logic [hsh_pkg::PLANE_W-1:0]     plane;
    logic [hsh_pkg::DIM_W-1:0]       dim;
    logic [hsh_pkg::VALUE_W-1:0]     value;
  } hash_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [31:0]                s_tdata = '0;   // plane_index, dim_index, value, zero pad
  logic [0:0]                 s_tuser = '0;   // opcode
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [31:0]                m_tdata;        // signature, vector_number
  logic                       cfg_we = 1'b0;
  logic [hsh_pkg::LEN_W-1:0]  cfg_wdata = '0; // vector_length

  hyperplane_sign_hash dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // stimulus and expectation stores
  hash_item_t         stim_q[$];
  hsh_pkg::result_t   signature_q[$];
  hash_item_t         drv_item;
  int                 pushed_cnt   = 0;
  int                 accepted_cnt = 0;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;
  bit                 hold_req     = 1'b0;
  bit                 hold_taken   = 1'b0;
  int                 hold_left    = 0;

  // predictor state
  logic [hsh_pkg::VALUE_W-1:0] coef_mem [NPLANES][DIMS] = '{default: '{default: '0}};
  logic [hsh_pkg::SUM_W-1:0]   plane_sum [NPLANES] = '{default: '0};
  int unsigned                 elem_pos  = 0;
  logic [hsh_pkg::VNUM_W-1:0]  vec_count = '0;
  logic [hsh_pkg::LEN_W-1:0]   vec_len   = hsh_pkg::LEN_RESET;

  // run statistics
  int err_count   = 0;
  int loads_seen  = 0;
  int elems_seen  = 0;
  int sigs_seen   = 0;
  int in_stalls   = 0;

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  function automatic int eff_len(logic [hsh_pkg::LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > DIMS) return DIMS;
    return int'(len);
  endfunction

  // loads fill coef_mem, elements fold into the sums; a completed vector yields a signature
  function automatic void hash_step(hash_item_t it);
    logic signed [hsh_pkg::PROD_W-1:0] prod;
    logic [hsh_pkg::SIG_W-1:0]         sig;
    hsh_pkg::result_t                  res;
    if (it.op == hsh_pkg::OP_LOAD) begin
      coef_mem[it.plane][it.dim] = it.value;
      return;
    end
    if (elem_pos < DIMS) begin
      for (int j = 0; j < NPLANES; j++) begin
        prod = $signed(it.value) * $signed(coef_mem[j][elem_pos]);
        plane_sum[j] = plane_sum[j] +
                       {{(hsh_pkg::SUM_W-hsh_pkg::PROD_W){prod[hsh_pkg::PROD_W-1]}}, prod};
      end
    end
    elem_pos++;
    if (elem_pos < eff_len(vec_len)) return;
    sig = '0;
    for (int j = 0; j < NPLANES; j++)
      if (plane_sum[j] != 0 && !plane_sum[j][hsh_pkg::SUM_W-1]) sig[NPLANES-1-j] = 1'b1;
    res.signature     = sig;
    res.vector_number = vec_count;
    signature_q.insert(signature_q.size(), res);
    plane_sum = '{default: '0};
    elem_pos  = 0;
    vec_count = vec_count + 1'b1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        drv_item = stim_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, drv_item.value, drv_item.dim, drv_item.plane};
        s_tuser  <= drv_item.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a one-off long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // input monitor and predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) vec_len = cfg_wdata;
      if (s_tvalid && !s_tready) in_stalls++;
      if (s_tvalid && s_tready) begin
        hash_item_t it;
        it.op    = hsh_pkg::opcode_t'(s_tuser[0]);
        it.plane = s_tdata[3:0];
        it.dim   = s_tdata[10:4];
        it.value = s_tdata[26:11];
        if (it.op == hsh_pkg::OP_LOAD) loads_seen++;
        else elems_seen++;
        hash_step(it);
        accepted_cnt++;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    hsh_pkg::result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (signature_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", m_tdata));
      end else begin
        want = signature_q.pop_front();
        sigs_seen++;
        if (got.signature !== want.signature)
          report_mismatch($sformatf("vector %0d signature %h, expected %h",
                                    want.vector_number, got.signature, want.signature));
        if (got.vector_number !== want.vector_number)
          report_mismatch($sformatf("vector_number %0d, expected %0d",
                                    got.vector_number, want.vector_number));
      end
    end
  end

  function automatic void push_item(hsh_pkg::opcode_t op, int plane, int dim,
                                    logic [hsh_pkg::VALUE_W-1:0] value);
    hash_item_t it;
    it.op    = op;
    it.plane = plane[hsh_pkg::PLANE_W-1:0];
    it.dim   = dim[hsh_pkg::DIM_W-1:0];
    it.value = value;
    stim_q.insert(stim_q.size(), it);
    pushed_cnt++;
  endfunction

  function automatic logic [hsh_pkg::VALUE_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom();
    case (r[2:0])
      3'd0:    return 16'h8000;
      3'd1:    return 16'h7FFF;
      3'd2:    return 16'h0000;
      default: return r[31:16];
    endcase
  endfunction

  // elements with the odd coefficient rewrite slipped in; returns transactions queued
  function automatic int feed_elements(int n);
    int cnt;
    cnt = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(5) == 0) begin
        push_item(hsh_pkg::OP_LOAD, $urandom_range(NPLANES-1), $urandom_range(DIMS-1),
                  pick_value());
        cnt++;
      end
      push_item(hsh_pkg::OP_DATA, $urandom_range(NPLANES-1), $urandom_range(DIMS-1),
                pick_value());
      cnt++;
    end
    return cnt;
  endfunction

  // wait until everything queued has been taken and every signature has come back
  task automatic drain();
    while (accepted_cnt != pushed_cnt || signature_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [hsh_pkg::LEN_W-1:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // elements only ever reach the loaded rows: long lengths get a part-vector that a
  // later, shorter length finishes
  task automatic random_traffic(int budget);
    int sent, n_vec, eff, room;
    logic [hsh_pkg::LEN_W-1:0] len;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(9))
        0:       len = 8'd0;
        1:       len = 8'd128;
        2:       len = $urandom_range(255, 129);
        3:       len = $urandom_range(127, FILL_ROWS + 1);
        4, 5:    len = $urandom_range(FILL_ROWS, 9);
        default: len = $urandom_range(8, 1);
      endcase
      write_length(len);
      eff = eff_len(len);
      if (eff > FILL_ROWS) begin
        room = FILL_ROWS - 1 - int'(elem_pos);
        sent += feed_elements($urandom_range(room));
      end else begin
        // close the open vector first, then whole ones
        sent += feed_elements((int'(elem_pos) >= eff) ? 1 : eff - int'(elem_pos));
        n_vec = $urandom_range(3);
        repeat (n_vec) sent += feed_elements(eff);
        // leave a part-vector behind now and then, so the next length lands mid-vector
        if (eff > 1 && $urandom_range(2) == 0)
          sent += feed_elements($urandom_range(eff - 1, 1));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    snd_idle_pct = 18;
    rcv_idle_pct = 76;

    // fill every row that an element can reach, so no read hits an unwritten entry
    for (int d = 0; d < FILL_ROWS; d++)
      for (int p = 0; p < NPLANES; p++)
        push_item(hsh_pkg::OP_LOAD, p, d, pick_value());

    // directed: extreme elements, zero sums, mixed signs, length corner cases
    write_length(8'd1);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h7FFF);
    push_item(hsh_pkg::OP_DATA, 15, 127, 16'h8000);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h0000);
    push_item(hsh_pkg::OP_LOAD, 0, 0, 16'h7FFF);
    push_item(hsh_pkg::OP_LOAD, 15, 0, 16'h8000);
    push_item(hsh_pkg::OP_LOAD, 5, 0, 16'h0000);
    push_item(hsh_pkg::OP_LOAD, 10, 0, 16'h0001);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h7FFF);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h8000);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h0001);
    write_length(8'd0);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'hFFFF);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h1234);
    write_length(8'd3);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h4000);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'hC000);
    // shrink to the count already received
    write_length(8'd2);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h2000);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'hE000);
    push_item(hsh_pkg::OP_DATA, 0, 0, 16'h0FFF);

    random_traffic(60);

    snd_idle_pct = 76;
    rcv_idle_pct = 18;
    // length above the store depth: clamped to it, and the part-vector is finished by a shorter one
    write_length(8'hFF);
    void'(feed_elements(FILL_ROWS - 1 - int'(elem_pos)));
    random_traffic(60);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_traffic(40);

    // back-pressure: receiver stops dead while single-element vectors keep arriving
    write_length(8'd1);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      push_item(hsh_pkg::OP_DATA, $urandom_range(NPLANES-1), $urandom_range(DIMS-1),
                pick_value());
    drain();

    $display("Run covered %0d coefficient loads and %0d elements, %0d signatures checked",
             loads_seen, elems_seen, sigs_seen);
    $display("Lengths from zero to past the store depth; input held off for %0d cycles",
             in_stalls);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout: %0d transactions outstanding, %0d signatures awaited",
             pushed_cnt - accepted_cnt, signature_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
